### hw/rtl/u8gram_pkg.sv
// Shared types and encoding constants for the UTF-8 to compact gram encoder.
package u8gram_pkg;

   // Input beat: one raw UTF-8 byte plus end-of-text marker.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_of_text;
   } req_type;

   // Output beat: one byte of the compact form plus end-of-character marker.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_char;
   } rsp_type;

   // One decoded code point, as passed from the decoder to the serializer.
   typedef logic [20:0] code_point_type;

   // Decoder lead byte patterns
   localparam logic [7:0] LeadTwoMask    = 8'hE0;
   localparam logic [7:0] LeadTwoCode    = 8'hC0;
   localparam logic [7:0] LeadThreeMask  = 8'hF0;
   localparam logic [7:0] LeadThreeCode  = 8'hE0;
   localparam logic [7:0] LeadFourMask   = 8'hF8;
   localparam logic [7:0] LeadFourCode   = 8'hF0;

   // Encoder constants
   localparam logic [7:0]  NulReplace     = 8'hE0;
   localparam logic [7:0]  ZeroLowPrefix  = 8'hE1;
   localparam logic [7:0]  HeaderBase     = 8'hE0;
   localparam logic [7:0]  MidOffset      = 8'h40;
   localparam logic [7:0]  GroupMark      = 8'h80;
   localparam code_point_type MidLow      = 21'h004000;
   localparam code_point_type MidHigh     = 21'h00A000;

endpackage : u8gram_pkg

### hw/rtl/u8gram_front.sv
// UTF-8 decoder front end: accepts input beats and pushes finished code points.
module u8gram_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  u8gram_pkg::req_type        req_data,
   input  logic                       queue_full,
   output logic                       push,
   output u8gram_pkg::code_point_type push_data
);
   import u8gram_pkg::*;

   code_point_type acc_ff, acc_in;
   logic [1:0]     pend_ff, pend_in;
   logic           accept;
   logic [7:0]     b;
   logic [1:0]     pend_dec;
   code_point_type acc_merged;
   code_point_type cont_bits;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign b         = req_data.in_byte;
   assign pend_dec  = pend_ff - 2'd1;

   // Place the six payload bits of a continuation byte in the next slot.
   always_comb begin
      unique case (pend_dec)
         2'd2:    cont_bits = {3'b0, b[5:0], 12'b0};
         2'd1:    cont_bits = {9'b0, b[5:0], 6'b0};
         default: cont_bits = {15'b0, b[5:0]};
      endcase
      acc_merged = acc_ff | cont_bits;
   end

   always_comb begin
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      push      = 1'b0;
      push_data = {13'b0, b};
      if (accept) begin
         if (pend_ff == 2'd0) begin
            priority if (!b[7]) begin
               push = 1'b1;
            end else if ((b & LeadTwoMask) == LeadTwoCode) begin
               acc_in  = {10'b0, b[4:0], 6'b0};
               pend_in = 2'd1;
            end else if ((b & LeadThreeMask) == LeadThreeCode) begin
               acc_in  = {5'b0, b[3:0], 12'b0};
               pend_in = 2'd2;
            end else if ((b & LeadFourMask) == LeadFourCode) begin
               acc_in  = {b[2:0], 18'b0};
               pend_in = 2'd3;
            end else begin
               // stray byte stands for itself
               push = 1'b1;
            end
         end else begin
            pend_in = pend_dec;
            if (pend_dec == 2'd0) begin
               push      = 1'b1;
               push_data = acc_merged;
               acc_in    = '0;
            end else begin
               acc_in = acc_merged;
            end
         end
         // end of text drops any open sequence
         if (req_data.last_of_text) begin
            acc_in  = '0;
            pend_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= 2'd0;
      end else begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

endmodule : u8gram_front

### hw/rtl/u8gram_queue.sv
// Small code point queue between the decoder and the serializer.
module u8gram_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  u8gram_pkg::code_point_type push_data,
   output logic                       full,
   input  logic                       pop,
   output u8gram_pkg::code_point_type pop_data,
   output logic                       not_empty
);
   import u8gram_pkg::*;

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   code_point_type        mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full      = (count_ff == CountWidth'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : u8gram_queue

### hw/rtl/u8gram_back.sv
// Serializer back end: code point to compact bytes, one beat a cycle unless stalled.
module u8gram_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_not_empty,
   input  u8gram_pkg::code_point_type queue_head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output u8gram_pkg::rsp_type        rsp_data
);
   import u8gram_pkg::*;

   code_point_type cur_ff, cur_in;
   logic           busy_ff, busy_in;
   logic [2:0]     idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic           is_ascii;
   logic           is_mid;
   logic [2:0]     groups;
   logic [2:0]     total;
   logic [2:0]     sel;
   logic [6:0]     chunk [4];
   logic [7:0]     hi_byte;
   logic [7:0]     cur_byte;
   logic           cur_last;
   logic           advance;
   logic           load_next;

   // Classify the current code point and pick the byte at idx_ff.
   always_comb begin
      is_ascii = (cur_ff[20:7] == '0);
      is_mid   = (cur_ff >= MidLow) && (cur_ff < MidHigh);
      priority if (cur_ff[20:18] != '0) begin
         groups = 3'd4;
      end else if (cur_ff[17:11] != '0) begin
         groups = 3'd3;
      end else begin
         groups = 3'd2;
      end
      chunk[3] = {4'b0, cur_ff[20:18]};
      chunk[2] = cur_ff[17:11];
      chunk[1] = cur_ff[10:4];
      chunk[0] = {cur_ff[3:0], 3'b0};
      hi_byte  = cur_ff[15:8] + MidOffset;
      sel      = groups - idx_ff;

      priority if (is_ascii) begin
         total    = 3'd1;
         cur_byte = (cur_ff[6:0] == '0) ? NulReplace : {1'b0, cur_ff[6:0]};
      end else if (is_mid) begin
         total = 3'd2;
         if (cur_ff[7:0] == '0) begin
            cur_byte = (idx_ff == 3'd0) ? ZeroLowPrefix : hi_byte;
         end else begin
            cur_byte = (idx_ff == 3'd0) ? hi_byte : cur_ff[7:0];
         end
      end else begin
         total = groups + 3'd1;
         if (idx_ff == 3'd0) begin
            cur_byte = HeaderBase | {5'b0, groups};
         end else begin
            cur_byte = GroupMark | {1'b0, chunk[sel[1:0]]};
         end
      end
      cur_last = (idx_ff == total - 3'd1);
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign load_next = !busy_ff || (advance && cur_last);
   assign pop       = load_next && queue_not_empty;

   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in             = busy_ff;
         rsp_data_in.out_byte     = cur_byte;
         rsp_data_in.last_of_char = cur_last;
      end
      if (load_next) begin
         busy_in = queue_not_empty;
         cur_in  = queue_head;
         idx_in  = 3'd0;
      end else if (advance) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : u8gram_back

### hw/rtl/utf8_to_compact_gram_encoder_unit.sv
// Top level of the UTF-8 to compact gram encoder: decoder, code point queue, serializer.
//
//   channel | direction | handshake        | beat payload
//   --------+-----------+------------------+--------------------------------
//   req     | in        | req_valid/_stall | in_byte, last_of_text
//   rsp     | out       | rsp_valid/_stall | out_byte, last_of_char
//
// The decoder takes one input beat per cycle while the code point queue has
// room; a byte that finishes a code point pushes it into the queue.
// The serializer sends one output beat per cycle while rsp_stall is low; a code
// point has 1 to 5 compact bytes, and the rsp port sets the sustained rate.
// The output byte sits in a register, so rsp_stall holds it and backs up
// into the queue, and only a full queue raises req_stall.
// Synchronous reset clears the decoder state, the queue and the output valid.
module utf8_to_compact_gram_encoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  u8gram_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output u8gram_pkg::rsp_type rsp_data
);
   import u8gram_pkg::*;

   // decoder to queue
   logic           push;
   code_point_type push_data;
   logic           queue_full;

   // queue to serializer
   logic           pop;
   code_point_type queue_head;
   logic           queue_not_empty;

   // Decode UTF-8 and push each finished code point.
   u8gram_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // Buffer code points so each side can stall on its own.
   u8gram_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (queue_head),
      .not_empty (queue_not_empty)
   );

   // Emit the compact bytes of each code point, most significant group first.
   u8gram_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_head      (queue_head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule : utf8_to_compact_gram_encoder_unit
